// ----- rtl/bfgb_pkg.sv -----
// ----------------------------------------------------------------------------
// bfgb_pkg
// Shared types, constants and font geometry for the glyph blitter.
// ----------------------------------------------------------------------------
package bfgb_pkg;

    localparam int FONT_REGION = 16384;
    localparam int GLYPH_DEPTH = 131072;
    localparam int CHAR_LIMIT  = 128;
    localparam int WIDTH_DEPTH = 2048;

    localparam int GLYPH_AW  = $clog2(GLYPH_DEPTH);
    localparam int WIDTH_AW  = $clog2(WIDTH_DEPTH);
    // largest unwrapped glyph base: font*FONT_REGION + 160*index
    localparam int BASE_SPAN = 8 * FONT_REGION + 160 * 256;
    localparam int PTR_W     = $clog2((BASE_SPAN > GLYPH_DEPTH) ? BASE_SPAN : GLYPH_DEPTH) + 1;

    localparam logic [2:0] FONT_5  = 3'd0;
    localparam logic [2:0] FONT_40 = 3'd7;

    typedef enum logic [1:0] {
        CMD_LOAD_GLYPH = 2'd0,
        CMD_LOAD_WIDTH = 2'd1,
        CMD_DRAW       = 2'd2,
        CMD_MEASURE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        K_ROW  = 2'd0,
        K_DONE = 2'd1,
        K_ERR  = 2'd2
    } kind_t;

    typedef enum logic {
        REG_FONT_SELECT = 1'b0,
        REG_WIDTH_TEST  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WRAP,
        S_ROWRD,
        S_EMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] nbytes;
        logic [2:0] cols;
        logic [5:0] rows;
        logic [3:0] fixed_adv;
        logic       use_table;
    } geom_t;

    function automatic geom_t font_geom(input logic [2:0] font);
        geom_t g;
        unique case (font)
            3'd0:    g = '{8'd32,  8'd7,   3'd1, 6'd7,  4'd0, 1'b1};
            3'd1:    g = '{8'd32,  8'd16,  3'd2, 6'd8,  4'd0, 1'b1};
            3'd2:    g = '{8'd32,  8'd16,  3'd2, 6'd8,  4'd0, 1'b1};
            3'd3:    g = '{8'd32,  8'd12,  3'd1, 6'd12, 4'd8, 1'b0};
            3'd4:    g = '{8'd32,  8'd24,  3'd2, 6'd12, 4'd9, 1'b0};
            3'd5:    g = '{8'd32,  8'd54,  3'd3, 6'd18, 4'd0, 1'b1};
            3'd6:    g = '{8'd32,  8'd54,  3'd3, 6'd18, 4'd0, 1'b1};
            default: g = '{8'd45,  8'd160, 3'd4, 6'd40, 4'd0, 1'b1};
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/bitmap_font_glyph_blitter.sv -----
// ----------------------------------------------------------------------------
// bitmap_font_glyph_blitter
// Bitmap font character generator: glyph/width stores, row-by-row draw.
// ----------------------------------------------------------------------------
// Sequence: a load request writes its store when taken and gives no result.
//   A draw runs S_SETUP, S_WRAP (again per glyph-store wrap, no wrap with the
//   default sizes), then per glyph row S_ROWRD per column and S_EMIT, then
//   S_DONE; a measure skips the rows. One glyph byte per cycle is read from the
//   single glyph-store port while a row is read; a stalled result holds the draw.
// Reset: asynchronous, active low; clears control and configuration, not
//   the glyph and width stores, which hold garbage until loaded.
module bitmap_font_glyph_blitter
    import bfgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [16:0] load_address,
    input  logic [7:0]  load_data,
    input  logic [7:0]  char_code,
    input  logic [11:0] x_pos,
    input  logic [11:0] y_pos,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [11:0] row_x,
    output logic [12:0] row_y,
    output logic [31:0] row_bits,
    output logic [2:0]  row_bytes,
    output logic [12:0] next_x,
    output logic        last
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0] font_select_reg;
    logic       wtm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_select_reg <= '0;
            wtm_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FONT_SELECT: font_select_reg <= cfg_data;
                REG_WIDTH_TEST:  wtm_reg         <= cfg_data[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control and working registers
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [2:0]       font_reg;
    logic [7:0]       chr_reg;
    logic [11:0]      x_reg, y_reg;
    logic             rows_reg;      // draw with row output
    logic             err_reg, err_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [5:0]       row_reg, row_next;
    logic [1:0]       col_reg, col_next;
    logic             rd_pend_reg;
    logic [1:0]       rd_col_reg;
    logic [31:0]      rowbuf_reg, rowbuf_next;

    // output register
    logic             out_vld_reg;
    kind_t            out_kind_reg, out_kind_next;
    logic [11:0]      out_x_reg, out_x_next;
    logic [12:0]      out_y_reg, out_y_next;
    logic [31:0]      out_bits_reg, out_bits_next;
    logic [2:0]       out_nb_reg, out_nb_next;
    logic [12:0]      out_nx_reg, out_nx_next;
    logic             out_last_reg, out_last_next;
    logic             out_load;
    logic             out_free;

    geom_t            geom;
    logic             accept;
    logic             is_load;
    logic [7:0]       idx;
    logic             in_range;
    logic             last_col;
    logic             last_row;
    logic [PTR_W-1:0] base;
    logic [PTR_W-1:0] ptr_inc;
    logic             ptr_high;
    logic [7:0]       adv;
    logic [12:0]      ry;

    // stores
    logic [7:0]          glyph_mem [GLYPH_DEPTH];
    logic [7:0]          width_mem [WIDTH_DEPTH];
    logic [7:0]          glyph_rdata_reg;
    logic [7:0]          width_rdata_reg;
    logic                glyph_we, glyph_re;
    logic                width_we, width_re;
    logic [PTR_W-1:0]    ld_addr_ext;
    logic [GLYPH_AW-1:0] glyph_waddr;
    logic [WIDTH_AW-1:0] width_raddr;

    assign geom     = font_geom(font_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign is_load  = (cmd_t'(command) == CMD_LOAD_GLYPH) ||
                      (cmd_t'(command) == CMD_LOAD_WIDTH);
    assign out_free = !out_vld_reg || !out_stall;

    // character index and range check against the latched font
    assign idx      = chr_reg - geom.first;
    assign in_range = (chr_reg >= geom.first) && ({1'b0, chr_reg} < 9'(CHAR_LIMIT));
    assign last_col = ({1'b0, col_reg} == geom.cols - 3'd1);
    assign last_row = (row_reg == geom.rows - 6'd1);

    // glyph base: font region plus bytes per glyph times index, wrapped later
    assign base = PTR_W'(font_reg) * PTR_W'(FONT_REGION)
                + PTR_W'(geom.nbytes) * PTR_W'(idx);

    // running byte pointer, wraps at the end of the glyph store
    assign ptr_inc  = (ptr_reg == PTR_W'(GLYPH_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign ptr_high = (ptr_reg >= PTR_W'(GLYPH_DEPTH));

    // advance: fixed, table, or table minus two clamped at zero for 40 dot
    always_comb
    begin
        if (!geom.use_table)
            adv = 8'(geom.fixed_adv);
        else if (font_reg == FONT_40)
            adv = (width_rdata_reg >= 8'd2) ? width_rdata_reg - 8'd2 : 8'd0;
        else
            adv = width_rdata_reg;
    end

    // 5 dot font: rows 0 and 1 both land on y
    always_comb
    begin
        if (font_reg == FONT_5 && row_reg != '0)
            ry = 13'(y_reg) + 13'(row_reg) - 13'd1;
        else if (font_reg == FONT_5)
            ry = 13'(y_reg);
        else
            ry = 13'(y_reg) + 13'(row_reg);
    end

    // ------------------------------------------------------------------
    // load address mapping
    // ------------------------------------------------------------------
    always_comb
    begin
        ld_addr_ext = PTR_W'(load_address);
        if (ld_addr_ext >= PTR_W'(GLYPH_DEPTH))
            ld_addr_ext = ld_addr_ext - PTR_W'(GLYPH_DEPTH);
    end
    assign glyph_waddr = ld_addr_ext[GLYPH_AW-1:0];
    assign width_raddr = {font_reg, idx};

    assign glyph_we = accept && (cmd_t'(command) == CMD_LOAD_GLYPH);
    assign width_we = accept && (cmd_t'(command) == CMD_LOAD_WIDTH);
    assign glyph_re = (state_reg == S_ROWRD);
    assign width_re = (state_reg == S_SETUP) && geom.use_table;

    always_ff @(posedge clk)
    begin
        if (glyph_we)
            glyph_mem[glyph_waddr] <= load_data;
        if (glyph_re)
            glyph_rdata_reg <= glyph_mem[ptr_reg[GLYPH_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (width_we)
            width_mem[load_address[WIDTH_AW-1:0]] <= load_data;
        if (width_re)
            width_rdata_reg <= width_mem[width_raddr];
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !is_load)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                state_next = in_range ? S_WRAP : S_DONE;
            end
            S_WRAP:
            begin
                if (!ptr_high)
                    state_next = rows_reg ? S_ROWRD : S_DONE;
            end
            S_ROWRD:
            begin
                if (last_col)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = last_row ? S_DONE : S_ROWRD;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and result formation
    // ------------------------------------------------------------------
    always_comb
    begin
        err_next      = err_reg;
        ptr_next      = ptr_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        rowbuf_next   = rowbuf_reg;
        out_load      = 1'b0;
        out_kind_next = K_ROW;
        out_x_next    = '0;
        out_y_next    = '0;
        out_bits_next = '0;
        out_nb_next   = '0;
        out_nx_next   = '0;
        out_last_next = 1'b0;

        // new row starts empty so unused bytes read as zero
        if (state_reg == S_ROWRD && col_reg == '0)
            rowbuf_next = '0;
        // byte read last cycle lands in its column, first byte at the top
        if (rd_pend_reg)
        begin
            unique case (rd_col_reg)
                2'd0: rowbuf_next[31:24] = glyph_rdata_reg;
                2'd1: rowbuf_next[23:16] = glyph_rdata_reg;
                2'd2: rowbuf_next[15:8]  = glyph_rdata_reg;
                2'd3: rowbuf_next[7:0]   = glyph_rdata_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                err_next = 1'b0;
                row_next = '0;
                col_next = '0;
            end
            S_SETUP:
            begin
                err_next = !in_range;
                ptr_next = base;
            end
            S_WRAP:
            begin
                if (ptr_high)
                    ptr_next = ptr_reg - PTR_W'(GLYPH_DEPTH);
            end
            S_ROWRD:
            begin
                ptr_next = ptr_inc;
                col_next = last_col ? 2'd0 : col_reg + 2'd1;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = K_ROW;
                    out_x_next    = x_reg;
                    out_y_next    = ry;
                    out_bits_next = rowbuf_next;
                    out_nb_next   = geom.cols;
                    row_next      = last_row ? 6'd0 : row_reg + 6'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = err_reg ? K_ERR : K_DONE;
                    out_nx_next   = err_reg ? 13'd0 : 13'(x_reg) + 13'(adv);
                    out_last_next = 1'b1;
                end
            end
            default:
            begin
                err_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            err_reg     <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            rd_pend_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            err_reg     <= err_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            rd_pend_reg <= glyph_re;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    // request fields and working data need no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            font_reg <= font_select_reg;
            chr_reg  <= char_code;
            x_reg    <= x_pos;
            y_reg    <= y_pos;
            rows_reg <= (cmd_t'(command) == CMD_DRAW) && !wtm_reg;
        end
        ptr_reg    <= ptr_next;
        rd_col_reg <= col_reg;
        rowbuf_reg <= rowbuf_next;
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_bits_reg <= out_bits_next;
            out_nb_reg   <= out_nb_next;
            out_nx_reg   <= out_nx_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign kind      = out_kind_reg;
    assign row_x     = out_x_reg;
    assign row_y     = out_y_reg;
    assign row_bits  = out_bits_reg;
    assign row_bytes = out_nb_reg;
    assign next_x    = out_nx_reg;
    assign last      = out_last_reg;

endmodule

// ----- rtl/bfgb_checker.sv -----
// ----------------------------------------------------------------------------
// bfgb_assertions
// Port-level checks for the glyph blitter, bound to the top level.
// ----------------------------------------------------------------------------
module bfgb_assertions
    import bfgb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [0:0]  cfg_index,
    input logic [2:0]  cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  command,
    input logic [16:0] load_address,
    input logic [7:0]  load_data,
    input logic [7:0]  char_code,
    input logic [11:0] x_pos,
    input logic [11:0] y_pos,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [11:0] row_x,
    input logic [12:0] row_y,
    input logic [31:0] row_bits,
    input logic [2:0]  row_bytes,
    input logic [12:0] next_x,
    input logic        last
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_bits) && $stable(kind)
            && $stable(next_x) && $stable(last))
        else $error("result changed while stalled");

    // a draw or measure request blocks the request channel while it runs
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_DRAW || command == CMD_MEASURE)
            |=> in_stall)
        else $error("request taken while a character is in progress");

    // row writes are never the final result and always carry bytes
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == K_ROW |-> !last && row_bytes != 3'd0)
        else $error("malformed row result");

    // error and done results close the request and carry no bytes
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_ERR || kind == K_DONE) |-> last && row_bytes == 3'd0
            && row_bits == 32'd0)
        else $error("malformed closing result");

endmodule

bind bitmap_font_glyph_blitter bfgb_assertions u_bfgb_assertions (.*);

// ----- test/bfgb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgb_checker
// Watches the request and result channels of the glyph blitter, keeps its
// own copy of both stores and of the configuration, works out the rows and
// done items each request must give and compares them in order.
// ----------------------------------------------------------------------------
module bfgb_checker
    import bfgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [16:0] load_address,
    input  logic [7:0]  load_data,
    input  logic [7:0]  char_code,
    input  logic [11:0] x_pos,
    input  logic [11:0] y_pos,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [11:0] row_x,
    input  logic [12:0] row_y,
    input  logic [31:0] row_bits,
    input  logic [2:0]  row_bytes,
    input  logic [12:0] next_x,
    input  logic        last,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        kind_t       kind;
        logic [11:0] x;
        logic [12:0] y;
        logic [31:0] bits;
        logic [2:0]  nbytes;
        logic [12:0] nx;
        logic        last;
    } glyph_row_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] nbytes;
        logic [2:0] cols;
        logic [3:0] fixed_adv;
        logic       from_table;
    } shape_t;

    logic [7:0] glyph_copy [GLYPH_DEPTH];
    logic [7:0] width_copy [WIDTH_DEPTH];
    logic [2:0] font_sel;
    logic       measure_only;
    glyph_row_t expected_rows [$];

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        font_sel     = FONT_5;
        measure_only = 1'b0;
    end

    // indexed by font_select
    function automatic shape_t shape_of(input logic [2:0] f);
        shape_t s;
        case (f)
            3'd0:    s = {8'd32, 8'd7,   3'd1, 4'd0, 1'b1};
            3'd1:    s = {8'd32, 8'd16,  3'd2, 4'd0, 1'b1};
            3'd2:    s = {8'd32, 8'd16,  3'd2, 4'd0, 1'b1};
            3'd3:    s = {8'd32, 8'd12,  3'd1, 4'd8, 1'b0};
            3'd4:    s = {8'd32, 8'd24,  3'd2, 4'd9, 1'b0};
            3'd5:    s = {8'd32, 8'd54,  3'd3, 4'd0, 1'b1};
            3'd6:    s = {8'd32, 8'd54,  3'd3, 4'd0, 1'b1};
            default: s = {8'd45, 8'd160, 3'd4, 4'd0, 1'b1};
        endcase
        return s;
    endfunction

    task automatic predict_glyph();
        shape_t      s;
        glyph_row_t  row;
        int          idx;
        int          adv;
        int          base;
        int          nrows;
        int          r;
        int          c;
        int          addr;
        logic [31:0] bits;
        s   = shape_of(font_sel);
        row = '0;
        if (char_code < s.first || int'(char_code) >= CHAR_LIMIT) begin
            row.kind = K_ERR;
            row.last = 1'b1;
            expected_rows.push_back(row);
        end else begin
            idx = int'(char_code) - int'(s.first);
            if (!s.from_table) begin
                adv = s.fixed_adv;
            end else begin
                adv = width_copy[(int'(font_sel) * 256 + idx) % WIDTH_DEPTH];
                // widest font: table value minus 2, floored at zero
                if (font_sel == FONT_40)
                    adv = (adv >= 2) ? adv - 2 : 0;
            end
            if (command == CMD_DRAW && !measure_only) begin
                base  = int'(font_sel) * FONT_REGION + int'(s.nbytes) * idx;
                nrows = int'(s.nbytes) / int'(s.cols);
                for (r = 0; r < nrows; r++) begin
                    bits = '0;
                    for (c = 0; c < int'(s.cols); c++) begin
                        addr = (base + r * int'(s.cols) + c) % GLYPH_DEPTH;
                        bits = bits | ({glyph_copy[addr], 24'h0} >> (8 * c));
                    end
                    row.kind   = K_ROW;
                    row.x      = x_pos;
                    // smallest font: first two rows land on the same line
                    row.y      = 13'(int'(y_pos) + r -
                                     ((font_sel == FONT_5 && r != 0) ? 1 : 0));
                    row.bits   = bits;
                    row.nbytes = s.cols;
                    row.nx     = '0;
                    row.last   = 1'b0;
                    expected_rows.push_back(row);
                end
            end
            row      = '0;
            row.kind = K_DONE;
            row.nx   = 13'(int'(x_pos) + adv);
            row.last = 1'b1;
            expected_rows.push_back(row);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        glyph_row_t want;
        if (!rst_n) begin
            font_sel     = FONT_5;
            measure_only = 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_FONT_SELECT)
                    font_sel = cfg_data;
                else
                    measure_only = cfg_data[0];
            end
            if (out_valid && !out_stall) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t unexpected result: kind %0d next_x %0h", $time, kind,
                             next_x);
                    mismatches++;
                end else begin
                    want = expected_rows.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("row_x", want.x, row_x);
                    check_field("row_y", want.y, row_y);
                    check_field("row_bits", want.bits, row_bits);
                    check_field("row_bytes", want.nbytes, row_bytes);
                    check_field("next_x", want.nx, next_x);
                    check_field("last", want.last, last);
                end
            end
            if (in_valid && !in_stall) begin
                case (command)
                    CMD_LOAD_GLYPH: glyph_copy[load_address % GLYPH_DEPTH] = load_data;
                    CMD_LOAD_WIDTH: width_copy[load_address[WIDTH_AW-1:0]] = load_data;
                    default:        predict_glyph();
                endcase
            end
            outstanding = expected_rows.size();
        end
    end

endmodule

// ----- test/tb_bitmap_font_glyph_blitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_font_glyph_blitter
// Drives load, draw and measure requests into the glyph blitter with random
// gaps and result-side stalls; a checker beside the block predicts every
// row and done item and counts mismatches, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bitmap_font_glyph_blitter
    import bfgb_pkg::*;
();

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    // requests in the whole run, loads included
    localparam int ITEM_TARGET  = 380;
    // bound on the whole run; the slowest draw gives 41 results, each may be stalled
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;

    // store fill modes for prepare_char
    localparam int KEEP  = -1;   // load only entries never written
    localparam int FRESH = -2;   // rewrite every entry with random bytes
    localparam int SKIP  = -3;   // leave the glyph bytes alone

    localparam logic [2:0] FONT_6  = 3'd1;
    localparam logic [2:0] FONT_7  = 3'd2;
    localparam logic [2:0] FONT_9  = 3'd3;
    localparam logic [2:0] FONT_10 = 3'd4;
    localparam logic [2:0] FONT_15 = 3'd5;
    localparam logic [2:0] FONT_18 = 3'd6;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_TOP   = 8'h7F;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [2:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [16:0] load_address;
    logic [7:0]  load_data;
    logic [7:0]  char_code;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [1:0]  kind;
    logic [11:0] row_x;
    logic [12:0] row_y;
    logic [31:0] row_bits;
    logic [2:0]  row_bytes;
    logic [12:0] next_x;
    logic        last;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int stall_left = 0;
    int sent = 0;

    // current configuration, as the stimulus sees it
    logic [2:0] cur_font = FONT_5;
    logic       cur_wtm = 1'b0;
    // burst phases: no gaps on the request side / no stalls on the result side
    bit         quiet_tx = 1'b0;
    bit         quiet_rx = 1'b0;

    // which store entries hold a loaded value; draws only touch loaded ones
    bit glyph_loaded [GLYPH_DEPTH];
    bit width_loaded [WIDTH_DEPTH];

    bitmap_font_glyph_blitter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .load_address (load_address),
        .load_data    (load_data),
        .char_code    (char_code),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .row_x        (row_x),
        .row_y        (row_y),
        .row_bits     (row_bits),
        .row_bytes    (row_bytes),
        .next_x       (next_x),
        .last         (last)
    );

    bfgb_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .load_address (load_address),
        .load_data    (load_data),
        .char_code    (char_code),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .row_x        (row_x),
        .row_y        (row_y),
        .row_bits     (row_bits),
        .row_bytes    (row_bytes),
        .next_x       (next_x),
        .last         (last),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #(CLK_HALF) clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: after each accepted result, stall for a random hold, none in quiet phases.
    always @(posedge clk or negedge rst_n) begin
        int hold;
        if (!rst_n) begin
            out_stall  <= 1'b1;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            hold = quiet_rx ? 0 : $urandom_range(0, 5);
            stall_left <= hold;
            out_stall  <= (hold != 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic int first_char(input logic [2:0] f);
        return (f == FONT_40) ? int'(CHAR_DASH) : int'(CHAR_SPACE);
    endfunction

    function automatic int glyph_bytes(input logic [2:0] f);
        case (f)
            FONT_5:          return 7;
            FONT_6, FONT_7:  return 16;
            FONT_9:          return 12;
            FONT_10:         return 24;
            FONT_15, FONT_18: return 54;
            default:         return 160;
        endcase
    endfunction

    // glyph loads prepare_char would issue for a character of the current font
    function automatic int glyph_cost(input logic [7:0] chr, input int gval);
        int nbytes;
        int base;
        int n;
        int k;
        nbytes = glyph_bytes(cur_font);
        base   = int'(cur_font) * FONT_REGION +
                 nbytes * (int'(chr) - first_char(cur_font));
        n      = 0;
        for (k = 0; k < nbytes; k++) begin
            if (gval != KEEP || !glyph_loaded[base + k])
                n++;
        end
        return n;
    endfunction

    // One request: optional random gap with valid low, then hold valid and
    // the payload until the block takes it. Valid stays high on return so a
    // back-to-back request never drops it within a step.
    task automatic send_request(input cmd_t cmd, input logic [16:0] addr,
                                input logic [7:0] data, input logic [7:0] chr,
                                input logic [11:0] x, input logic [11:0] y);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        load_address <= addr;
        load_data    <= data;
        char_code    <= chr;
        x_pos        <= x;
        y_pos        <= y;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    // Wait until every predicted result is out, then let the block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Configuration is only touched while the block is idle; both registers
    // are written every time.
    task automatic set_config(input logic [2:0] f, input logic wtm);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FONT_SELECT;
        cfg_data  <= f;
        @(posedge clk);
        cfg_index <= REG_WIDTH_TEST;
        cfg_data  <= {2'b00, wtm};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_font  = f;
        cur_wtm   = wtm;
    endtask

    // Load the width entry and glyph bytes a character of the current font
    // reads. wval >= 0 forces the advance byte; gval >= 0 fills every glyph
    // byte with that value, FRESH rewrites them at random, KEEP fills gaps,
    // SKIP loads no glyph byte (measure only).
    task automatic prepare_char(input logic [7:0] chr, input int wval, input int gval);
        int idx;
        int nbytes;
        int base;
        int waddr;
        int k;
        idx    = int'(chr) - first_char(cur_font);
        nbytes = glyph_bytes(cur_font);
        waddr  = int'(cur_font) * 256 + idx;
        // fixed-advance fonts never read the width store
        if (cur_font != FONT_9 && cur_font != FONT_10 &&
            (wval != KEEP || !width_loaded[waddr])) begin
            // upper address bits are don't-care for width loads
            send_request(CMD_LOAD_WIDTH, {6'($urandom), 11'(waddr)},
                         (wval >= 0) ? 8'(wval) : 8'($urandom), 8'($urandom),
                         12'($urandom), 12'($urandom));
            width_loaded[waddr] = 1'b1;
        end
        base = int'(cur_font) * FONT_REGION + nbytes * idx;
        if (gval != SKIP) begin
            for (k = 0; k < nbytes; k++) begin
                if (gval != KEEP || !glyph_loaded[base + k]) begin
                    send_request(CMD_LOAD_GLYPH, 17'(base + k),
                                 (gval >= 0) ? 8'(gval) : 8'($urandom), 8'($urandom),
                                 12'($urandom), 12'($urandom));
                    glyph_loaded[base + k] = 1'b1;
                end
            end
        end
    endtask

    initial begin
        int         pick;
        int         phase_left;
        int         first;
        int         gmode;
        logic [7:0] pool [6];
        logic [7:0] chr;
        logic [16:0] addr;
        cmd_t       cmd;

        cfg_we       <= 1'b0;
        cfg_index    <= REG_FONT_SELECT;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        command      <= CMD_LOAD_GLYPH;
        load_address <= '0;
        load_data    <= '0;
        char_code    <= '0;
        x_pos        <= '0;
        y_pos        <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // Smallest font: blank glyph at the origin with a tiny advance, a
        // full glyph at the far corner with the widest advance.
        set_config(FONT_5, 1'b0);
        prepare_char(CHAR_SPACE, 3, 0);
        send_request(CMD_DRAW, '0, '0, CHAR_SPACE, 12'd0, 12'd0);
        prepare_char(CHAR_TOP, 255, 255);
        send_request(CMD_DRAW, '1, '1, CHAR_TOP, 12'hFFF, 12'hFFF);
        prepare_char(8'h41, KEEP, FRESH);
        send_request(CMD_MEASURE, '0, '0, 8'h41, 12'd100, 12'd7);
        // out of range: just below the first character, at the limit, top code
        send_request(CMD_DRAW, '0, '0, CHAR_SPACE - 8'd1, 12'd5, 12'd5);
        send_request(CMD_MEASURE, '0, '0, 8'(CHAR_LIMIT), 12'd5, 12'd5);
        send_request(CMD_DRAW, '1, '1, 8'hFF, 12'hFFF, 12'hFFF);

        // Widest font starts at the dash; advance saturates at zero for 0 and 1.
        set_config(FONT_40, 1'b0);
        prepare_char(CHAR_DASH, 0, 255);
        send_request(CMD_DRAW, '0, '0, CHAR_DASH, 12'hFFF, 12'hFFF);
        prepare_char(CHAR_DASH + 8'd1, 1, SKIP);
        send_request(CMD_MEASURE, '0, '0, CHAR_DASH + 8'd1, 12'd0, 12'd0);
        prepare_char(CHAR_TOP, 255, SKIP);
        send_request(CMD_MEASURE, '0, '0, CHAR_TOP, 12'hFFF, 12'd0);
        // a space is legal elsewhere but below this font's range
        send_request(CMD_DRAW, '0, '0, CHAR_SPACE, 12'd9, 12'd9);
        send_request(CMD_MEASURE, '0, '0, CHAR_DASH - 8'd1, 12'd9, 12'd9);
        send_request(CMD_DRAW, '0, '0, 8'h00, 12'd9, 12'd9);

        // fixed-advance fonts
        set_config(FONT_9, 1'b0);
        prepare_char(8'h7E, KEEP, FRESH);
        send_request(CMD_DRAW, '0, '0, 8'h7E, 12'($urandom), 12'($urandom));
        set_config(FONT_10, 1'b0);
        prepare_char(8'h21, KEEP, FRESH);
        send_request(CMD_DRAW, '0, '0, 8'h21, 12'($urandom), 12'($urandom));

        // width-test mode: draw only reports the advance
        set_config(FONT_18, 1'b1);
        prepare_char(8'h50, KEEP, SKIP);
        send_request(CMD_DRAW, '0, '0, 8'h50, 12'($urandom), 12'($urandom));
        send_request(CMD_MEASURE, '0, '0, 8'h50, 12'($urandom), 12'($urandom));

        // ---------------- random part ----------------
        // Phases of one configuration each; within a phase most requests
        // draw or measure a small pool of loaded characters, the rest are
        // out-of-range characters and stray loads.
        phase_left = 0;
        while (sent < ITEM_TARGET) begin
            if (phase_left == 0) begin
                set_config(3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0));
                quiet_tx = ($urandom_range(0, 4) == 0);
                quiet_rx = ($urandom_range(0, 4) == 0);
                first    = first_char(cur_font);
                foreach (pool[i])
                    pool[i] = 8'($urandom_range(first, CHAR_LIMIT - 1));
                phase_left = $urandom_range(10, 30);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                chr   = pool[$urandom_range(0, 5)];
                cmd   = ($urandom_range(0, 4) == 0) ? CMD_MEASURE : CMD_DRAW;
                gmode = ($urandom_range(0, 4) == 0) ? FRESH : KEEP;
                // a draw whose glyph loads overrun the request budget is
                // measured instead
                if (cmd == CMD_DRAW && !cur_wtm &&
                    glyph_cost(chr, gmode) + 2 > ITEM_TARGET - sent)
                    cmd = CMD_MEASURE;
                // measures and width-test draws never read glyph bytes
                if (cmd == CMD_MEASURE || cur_wtm)
                    gmode = SKIP;
                prepare_char(chr,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : KEEP,
                             gmode);
                send_request(cmd, 17'($urandom), 8'($urandom), chr, 12'($urandom),
                             12'($urandom));
            end else if (pick < 82) begin
                if ($urandom_range(0, 1) == 0)
                    chr = 8'($urandom_range(CHAR_LIMIT, 255));
                else
                    chr = 8'($urandom_range(0, first - 1));
                cmd = ($urandom_range(0, 1) == 0) ? CMD_MEASURE : CMD_DRAW;
                send_request(cmd, 17'($urandom), 8'($urandom), chr, 12'($urandom),
                             12'($urandom));
            end else begin
                // stray load anywhere in either store
                addr = 17'($urandom);
                if ($urandom_range(0, 1) == 0) begin
                    send_request(CMD_LOAD_GLYPH, addr, 8'($urandom), 8'($urandom),
                                 12'($urandom), 12'($urandom));
                    glyph_loaded[addr] = 1'b1;
                end else begin
                    send_request(CMD_LOAD_WIDTH, addr, 8'($urandom), 8'($urandom),
                                 12'($urandom), 12'($urandom));
                    width_loaded[addr[WIDTH_AW-1:0]] = 1'b1;
                end
            end
            phase_left--;
        end

        // ---------------- verdict ----------------
        drain_results();
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
